### src/dcl_pkg.sv
package dcl_pkg;

    localparam int DEF_MAX_POINTS  = 256;
    localparam int DEF_MAX_DIMS    = 4;
    localparam int DEF_COORD_WIDTH = 16;

    localparam int FIELD_W   = 16;
    localparam int OUT_W     = 9;
    localparam int QIDX_W    = 8;
    localparam int EPS_W     = 36;
    localparam int MINP_W    = 9;
    localparam int DIMS_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 36;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } dcl_cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EPS  = 2'd0,
        CFG_MINP = 2'd1,
        CFG_DIMS = 2'd2
    } dcl_cfg_idx_t;

    typedef struct packed {
        dcl_cmd_t                   command;
        logic signed [FIELD_W-1:0]  coord_0;
        logic signed [FIELD_W-1:0]  coord_1;
        logic signed [FIELD_W-1:0]  coord_2;
        logic signed [FIELD_W-1:0]  coord_3;
        logic                       last_point;
        logic [QIDX_W-1:0]          query_index;
    } dcl_in_item_t;

    typedef struct packed {
        logic [OUT_W-1:0] point_label;
        logic [OUT_W-1:0] cluster_count;
        logic [OUT_W-1:0] point_count;
        logic             overflow;
        logic             bad_index;
    } dcl_out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QRESP,
        ST_SEED_RD,
        ST_SEED_CHK,
        ST_REF_RD,
        ST_REF_LAT,
        ST_COUNT,
        ST_DECIDE,
        ST_LABEL,
        ST_NEXT,
        ST_POP_RD,
        ST_POP_LAT
    } dcl_state_t;

endpackage

### src/dcl_in_if.sv
interface dcl_in_if;
    import dcl_pkg::*;

    logic         valid;
    logic         ready;
    dcl_in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/dcl_out_if.sv
interface dcl_out_if;
    import dcl_pkg::*;

    logic          valid;
    logic          ready;
    dcl_out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/dcl_ram.sv
module dcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### src/dcl_cell.sv
// One dimension of the distance chain: adds this coordinate's squared
// difference to the running sum when in use; hands item to next cell.
module dcl_cell #(
    parameter int MAX_DIMS    = 4,
    parameter int COORD_WIDTH = 16,
    parameter int DIM         = 0,
    parameter int TAG_W       = 10,
    parameter int SUM_W       = 35
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [$clog2(MAX_DIMS+1)-1:0]      dims_eff,
    input  logic [MAX_DIMS*COORD_WIDTH-1:0]    ref_point,
    input  logic                               in_valid,
    input  logic [TAG_W-1:0]                   in_tag,
    input  logic [MAX_DIMS*COORD_WIDTH-1:0]    in_point,
    input  logic [SUM_W-1:0]                   in_sum,
    output logic                               out_valid,
    output logic [TAG_W-1:0]                   out_tag,
    output logic [MAX_DIMS*COORD_WIDTH-1:0]    out_point,
    output logic [SUM_W-1:0]                   out_sum
);
    localparam int CW    = COORD_WIDTH;
    localparam int DIM_W = $clog2(MAX_DIMS+1);

    logic signed [CW:0]           diff;
    logic [CW-1:0]                mag;
    logic [2*CW-1:0]              sq;
    logic                         active;

    logic                         valid_reg;
    logic [TAG_W-1:0]             tag_reg;
    logic [MAX_DIMS*CW-1:0]       point_reg;
    logic [SUM_W-1:0]             sum_reg;
    logic [SUM_W-1:0]             sum_next;

    always_comb
    begin
        diff = $signed({in_point[DIM*CW+CW-1], in_point[DIM*CW +: CW]})
             - $signed({ref_point[DIM*CW+CW-1], ref_point[DIM*CW +: CW]});
        mag  = diff[CW] ? CW'(-diff) : diff[CW-1:0];
        sq   = mag * mag;
        active = DIM_W'(DIM) < dims_eff;
        sum_next = active ? in_sum + SUM_W'(sq) : in_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg   <= in_tag;
        point_reg <= in_point;
        sum_reg   <= sum_next;
    end

    assign out_valid = valid_reg;
    assign out_tag   = tag_reg;
    assign out_point = point_reg;
    assign out_sum   = sum_reg;
endmodule

### src/density_clustering_engine.sv
// Channel | Dir | Handshake     | Item
// req     | in  | valid/ready   | command, coord_0..3, last_point, query_index
// rsp     | out | valid/ready   | point_label, cluster_count, point_count, overflow, bad_index
// cfg     | in  | cfg_we only   | cfg_index selects eps_squared, min_points, dims_in_use
//
// A load is taken in the idle state; a query waits in ST_QRESP for rsp
// to drain. After the last point, the run scans the point memory for
// each unlabelled seed and each popped point: one pass to count, a
// second to label on a core point.
// No clearing pass after reset; labels are written as points load.
// req is not taken while a run or query is in progress.
module density_clustering_engine #(
    parameter int MAX_POINTS  = dcl_pkg::DEF_MAX_POINTS,
    parameter int MAX_DIMS    = dcl_pkg::DEF_MAX_DIMS,
    parameter int COORD_WIDTH = dcl_pkg::DEF_COORD_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    dcl_in_if.sink                          req,
    dcl_out_if.source                       rsp,
    input  logic                            cfg_we,
    input  logic [dcl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dcl_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dcl_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int PW     = MAX_DIMS * CW;
    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int DIM_W  = $clog2(MAX_DIMS + 1);
    localparam int SUM_W  = 2 * CW + $clog2(MAX_DIMS) + 1;
    localparam int CMP_W  = (SUM_W > EPS_W) ? SUM_W : EPS_W;
    localparam int QW     = (CNT_W > QIDX_W) ? CNT_W : QIDX_W;
    localparam int MW     = (CNT_W > MINP_W) ? CNT_W : MINP_W;
    localparam int LR_W   = CNT_W + 2;
    localparam int LBL_V  = CNT_W + 1;
    localparam int LBL_NZ = CNT_W;
    localparam int TAG_W  = IDX_W + 2;

    dcl_state_t state_reg, state_next;

    logic [EPS_W-1:0]  eps_reg;
    logic [MINP_W-1:0] minp_reg;
    logic [DIMS_W-1:0] dims_reg;

    logic              open_reg, open_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  clusters_reg, clusters_next;
    logic [CNT_W-1:0]  seed_reg, seed_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic              phase_reg, phase_next;
    logic [PW-1:0]     ref_reg, ref_next;
    logic [CNT_W-1:0]  nbr_reg, nbr_next;
    logic [CNT_W-1:0]  depth_reg, depth_next;
    logic              issuing_reg, issuing_next;
    logic [IDX_W-1:0]  issue_idx_reg, issue_idx_next;
    logic              s0_valid_reg;
    logic [IDX_W-1:0]  s0_idx_reg;
    logic              bad_reg, bad_next;
    logic              out_valid_reg, out_valid_next;
    dcl_out_item_t     out_data_reg, out_data_next;

    // memory ports
    logic              pt_we, pt_re;
    logic [IDX_W-1:0]  pt_waddr, pt_raddr;
    logic [PW-1:0]     pt_wdata, pt_rdata;
    logic              lb_we, lb_re;
    logic [IDX_W-1:0]  lb_waddr, lb_raddr;
    logic [LR_W-1:0]   lb_wdata, lb_rdata;
    logic              sk_we, sk_re;
    logic [IDX_W-1:0]  sk_waddr, sk_raddr;
    logic [IDX_W-1:0]  sk_wdata, sk_rdata;

    // distance chain
    logic              ch_valid [MAX_DIMS+1];
    logic [TAG_W-1:0]  ch_tag   [MAX_DIMS+1];
    logic [PW-1:0]     ch_point [MAX_DIMS+1];
    logic [SUM_W-1:0]  ch_sum   [MAX_DIMS+1];

    logic [DIM_W-1:0]  dims_eff;
    logic [3:0]        dims4;
    logic [PW-1:0]     load_point;
    logic [FIELD_W-1:0] coord_u [4];
    logic [CNT_W-1:0]  load_idx;
    logic              req_fire;
    logic              end_valid, end_hit, end_last, end_vflag, end_nzflag;
    logic [IDX_W-1:0]  end_idx;
    logic [IDX_W-1:0]  last_idx;
    logic              out_free;

    dcl_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_point_ram (
        .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
        .re(pt_re), .raddr(pt_raddr), .rdata(pt_rdata)
    );

    dcl_ram #(.WIDTH(LR_W), .DEPTH(MAX_POINTS)) u_label_ram (
        .clk(clk), .we(lb_we), .waddr(lb_waddr), .wdata(lb_wdata),
        .re(lb_re), .raddr(lb_raddr), .rdata(lb_rdata)
    );

    dcl_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_stack_ram (
        .clk(clk), .we(sk_we), .waddr(sk_waddr), .wdata(sk_wdata),
        .re(sk_re), .raddr(sk_raddr), .rdata(sk_rdata)
    );

    // stage 0 is the memory read; flags ride along with the index
    assign ch_valid[0] = s0_valid_reg;
    assign ch_tag[0]   = {lb_rdata[LBL_V], lb_rdata[LBL_NZ], s0_idx_reg};
    assign ch_point[0] = pt_rdata;
    assign ch_sum[0]   = '0;

    for (genvar g = 0; g < MAX_DIMS; g++)
    begin : g_cell
        dcl_cell #(
            .MAX_DIMS(MAX_DIMS), .COORD_WIDTH(CW), .DIM(g),
            .TAG_W(TAG_W), .SUM_W(SUM_W)
        ) u_cell (
            .clk(clk), .rst_n(rst_n), .dims_eff(dims_eff), .ref_point(ref_reg),
            .in_valid(ch_valid[g]), .in_tag(ch_tag[g]),
            .in_point(ch_point[g]), .in_sum(ch_sum[g]),
            .out_valid(ch_valid[g+1]), .out_tag(ch_tag[g+1]),
            .out_point(ch_point[g+1]), .out_sum(ch_sum[g+1])
        );
    end

    always_comb
    begin
        dims4 = {1'b0, dims_reg};
        if (dims_reg == '0)
        begin
            dims_eff = DIM_W'(1);
        end
        else if (dims4 > 4'(MAX_DIMS))
        begin
            dims_eff = DIM_W'(MAX_DIMS);
        end
        else
        begin
            dims_eff = DIM_W'(dims4);
        end
    end

    always_comb
    begin
        coord_u[0] = $unsigned(req.data.coord_0);
        coord_u[1] = $unsigned(req.data.coord_1);
        coord_u[2] = $unsigned(req.data.coord_2);
        coord_u[3] = $unsigned(req.data.coord_3);
        load_point = '0;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            if (d < 4)
            begin
                load_point[d*CW +: CW] = CW'(coord_u[d]);
            end
        end
    end

    assign end_valid  = ch_valid[MAX_DIMS];
    assign end_idx    = ch_tag[MAX_DIMS][IDX_W-1:0];
    assign end_nzflag = ch_tag[MAX_DIMS][IDX_W];
    assign end_vflag  = ch_tag[MAX_DIMS][IDX_W+1];
    assign last_idx   = IDX_W'(count_reg - CNT_W'(1));
    assign end_hit    = end_valid && (CMP_W'(ch_sum[MAX_DIMS]) <= CMP_W'(eps_reg));
    assign end_last   = end_valid && (end_idx == last_idx);
    assign load_idx   = open_reg ? count_reg : '0;
    assign req_fire   = req.valid && req.ready;
    assign out_free   = !out_valid_reg || rsp.ready;

    assign req.ready  = (state_reg == ST_IDLE);
    assign rsp.valid  = out_valid_reg;
    assign rsp.data   = out_data_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.data.command == CMD_QUERY)
                    begin
                        state_next = ST_QRESP;
                    end
                    else if (req.data.last_point)
                    begin
                        state_next = ST_SEED_RD;
                    end
                end
            end
            ST_QRESP:    state_next = out_free ? ST_IDLE : ST_QRESP;
            ST_SEED_RD:  state_next = (seed_reg >= count_reg) ? ST_IDLE : ST_SEED_CHK;
            ST_SEED_CHK: state_next = lb_rdata[LBL_V] ? ST_SEED_RD : ST_REF_RD;
            ST_REF_RD:   state_next = ST_REF_LAT;
            ST_REF_LAT:  state_next = ST_COUNT;
            ST_COUNT:    state_next = end_last ? ST_DECIDE : ST_COUNT;
            ST_DECIDE:
            begin
                state_next = (MW'(nbr_reg) >= MW'(minp_reg)) ? ST_LABEL : ST_NEXT;
            end
            ST_LABEL:    state_next = end_last ? ST_NEXT : ST_LABEL;
            ST_NEXT:     state_next = (depth_reg != '0) ? ST_POP_RD : ST_SEED_RD;
            ST_POP_RD:   state_next = ST_POP_LAT;
            ST_POP_LAT:  state_next = ST_REF_LAT;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        open_next      = open_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        clusters_next  = clusters_reg;
        seed_next      = seed_reg;
        cur_next       = cur_reg;
        phase_next     = phase_reg;
        ref_next       = ref_reg;
        nbr_next       = nbr_reg;
        depth_next     = depth_reg;
        issuing_next   = issuing_reg;
        issue_idx_next = issue_idx_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_data_next  = out_data_reg;

        pt_we = 1'b0; pt_waddr = IDX_W'(load_idx); pt_wdata = load_point;
        pt_re = 1'b0; pt_raddr = issue_idx_reg;
        lb_we = 1'b0; lb_waddr = IDX_W'(load_idx); lb_wdata = '0;
        lb_re = 1'b0; lb_raddr = issue_idx_reg;
        sk_we = 1'b0; sk_waddr = IDX_W'(depth_reg); sk_wdata = end_idx;
        sk_re = 1'b0; sk_raddr = IDX_W'(depth_reg - CNT_W'(1));

        // scan issue, one stored point a cycle
        if (issuing_reg)
        begin
            pt_re = 1'b1;
            lb_re = 1'b1;
            issue_idx_next = issue_idx_reg + IDX_W'(1);
            if (issue_idx_reg == last_idx)
            begin
                issuing_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.data.command == CMD_QUERY)
                    begin
                        lb_re    = 1'b1;
                        lb_raddr = IDX_W'(req.data.query_index);
                        bad_next = QW'(req.data.query_index) >= QW'(count_reg);
                    end
                    else
                    begin
                        if (!open_reg)
                        begin
                            open_next     = 1'b1;
                            ovf_next      = 1'b0;
                            clusters_next = '0;
                            count_next    = '0;
                        end
                        if (load_idx < CNT_W'(MAX_POINTS))
                        begin
                            pt_we      = 1'b1;
                            lb_we      = 1'b1;
                            count_next = load_idx + CNT_W'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        if (req.data.last_point)
                        begin
                            open_next  = 1'b0;
                            seed_next  = '0;
                            depth_next = '0;
                        end
                    end
                end
            end
            ST_QRESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.point_label = (!bad_reg && lb_rdata[LBL_V])
                                              ? OUT_W'(lb_rdata[CNT_W-1:0]) : '0;
                    out_data_next.cluster_count = OUT_W'(clusters_reg);
                    out_data_next.point_count   = OUT_W'(count_reg);
                    out_data_next.overflow      = ovf_reg;
                    out_data_next.bad_index     = bad_reg;
                end
            end
            ST_SEED_RD:
            begin
                lb_re    = 1'b1;
                lb_raddr = IDX_W'(seed_reg);
            end
            ST_SEED_CHK:
            begin
                if (lb_rdata[LBL_V])
                begin
                    seed_next = seed_reg + CNT_W'(1);
                end
                else
                begin
                    cur_next   = IDX_W'(seed_reg);
                    phase_next = 1'b1;
                end
            end
            ST_REF_RD:
            begin
                pt_re    = 1'b1;
                pt_raddr = cur_reg;
            end
            ST_REF_LAT:
            begin
                ref_next       = pt_rdata;
                nbr_next       = '0;
                issuing_next   = 1'b1;
                issue_idx_next = '0;
            end
            ST_COUNT:
            begin
                if (end_hit)
                begin
                    nbr_next = nbr_reg + CNT_W'(1);
                end
            end
            ST_DECIDE:
            begin
                if (MW'(nbr_reg) >= MW'(minp_reg))
                begin
                    issuing_next   = 1'b1;
                    issue_idx_next = '0;
                    if (phase_reg)
                    begin
                        clusters_next = clusters_reg + CNT_W'(1);
                    end
                end
                else if (phase_reg)
                begin
                    // seed becomes noise
                    lb_we    = 1'b1;
                    lb_waddr = cur_reg;
                    lb_wdata = '0;
                    lb_wdata[LBL_V] = 1'b1;
                end
            end
            ST_LABEL:
            begin
                if (end_hit)
                begin
                    lb_waddr = end_idx;
                    lb_wdata = {1'b1, 1'b1, clusters_reg};
                    if (phase_reg)
                    begin
                        lb_we = 1'b1;
                        sk_we = end_idx != cur_reg;
                    end
                    else
                    begin
                        lb_we = !end_vflag || !end_nzflag;
                        sk_we = !end_vflag;
                    end
                    if (sk_we)
                    begin
                        depth_next = depth_reg + CNT_W'(1);
                    end
                end
            end
            ST_NEXT:
            begin
                if (depth_reg == '0)
                begin
                    seed_next = seed_reg + CNT_W'(1);
                end
            end
            ST_POP_RD:
            begin
                sk_re      = 1'b1;
                depth_next = depth_reg - CNT_W'(1);
            end
            ST_POP_LAT:
            begin
                cur_next   = sk_rdata;
                phase_next = 1'b0;
                pt_re      = 1'b1;
                pt_raddr   = sk_rdata;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            eps_reg       <= '0;
            minp_reg      <= MINP_W'(4);
            dims_reg      <= DIMS_W'(2);
            open_reg      <= 1'b0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            clusters_reg  <= '0;
            seed_reg      <= '0;
            phase_reg     <= 1'b0;
            nbr_reg       <= '0;
            depth_reg     <= '0;
            issuing_reg   <= 1'b0;
            issue_idx_reg <= '0;
            s0_valid_reg  <= 1'b0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            open_reg      <= open_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            clusters_reg  <= clusters_next;
            seed_reg      <= seed_next;
            phase_reg     <= phase_next;
            nbr_reg       <= nbr_next;
            depth_reg     <= depth_next;
            issuing_reg   <= issuing_next;
            issue_idx_reg <= issue_idx_next;
            s0_valid_reg  <= issuing_reg;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_EPS:  eps_reg  <= EPS_W'(cfg_data);
                    CFG_MINP: minp_reg <= MINP_W'(cfg_data);
                    CFG_DIMS: dims_reg <= DIMS_W'(cfg_data);
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        ref_reg      <= ref_next;
        s0_idx_reg   <= issue_idx_reg;
        out_data_reg <= out_data_next;
    end
endmodule
